/* src/ac_pkg.sv */
// Shared types, sizes and address helper for the multi-pattern matcher.
package ac_pkg;

    localparam int NODES    = 1024;
    localparam int ALPHA    = 26;
    localparam int NODE_W   = $clog2(NODES);
    localparam int SYM_W    = 5;
    localparam int CNT_W    = 8;
    localparam int TBL_DEPTH = NODES * ALPHA;
    localparam int TBL_AW   = $clog2(TBL_DEPTH);
    localparam int TOTAL_W  = NODE_W + 1;

    localparam logic [CNT_W-1:0] TERM_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_BUILD  = 2'd1;
    localparam logic [1:0] ACT_SCAN   = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_INS_RD,
        S_INS_INC,
        S_SCAN_RD,
        S_B_POP,
        S_B_V,
        S_B_P,
        S_B_SP,
        S_B_ST,
        S_B_S,
        S_B_O,
        S_B_ROW,
        S_EMIT_RD,
        S_EMIT
    } t_state;

    // Row-major table address: node * ALPHA + symbol
    function automatic logic [TBL_AW-1:0] tbl_addr(input logic [NODE_W-1:0] node,
                                                   input logic [SYM_W-1:0] sym);
        tbl_addr = TBL_AW'(node) * TBL_AW'(ALPHA) + TBL_AW'(sym);
    endfunction

endpackage

/* src/aho_corasick_matcher.sv */
// Multi-pattern matcher: trie insert, breadth-first link build and text scan.
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+----------------------------------------
//  s_axis    | in  | tvalid / tready        | tdata: symbol; tuser: action; tlast: last
//  m_axis    | out | tvalid / tready        | tdata: node, count, dict link, flags
//
// Between accepted transactions an insert passes through S_INS_RD, then S_INS_INC
// when it ends a pattern on an existing node, then S_EMIT_RD and S_EMIT; a scan
// through S_SCAN_RD, S_EMIT_RD and S_EMIT; an unused action or out-of-range symbol
// through S_EMIT_RD and S_EMIT. These states are set by the registered memory reads
// on the read-modify-write path. Build sweeps one transition-table row of 26 entries
// per trie node, plus the suffix-link lookups. After reset a clearing pass sweeps the
// child and transition tables; no transaction is accepted during it. A stalled result
// stays in the output register while the next input transaction is taken.
module aho_corasick_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [4:0] symbol, [7:5] zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] action
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [9:0] node, [17:10] match_count,
                                          // [27:18] dict_link, [28] has_dict_link,
                                          // [29] overflow, [31:30] zero
);

    localparam int NW = ac_pkg::NODE_W;
    localparam int AW = ac_pkg::TBL_AW;
    localparam int SW = ac_pkg::SYM_W;
    localparam int CW = ac_pkg::CNT_W;

    // Memories
    logic [NW-1:0] child_mem [ac_pkg::TBL_DEPTH];
    logic [NW-1:0] trans_mem [ac_pkg::TBL_DEPTH];
    logic [CW-1:0] term_mem  [ac_pkg::NODES];
    logic [NW-1:0] par_mem   [ac_pkg::NODES];
    logic [SW-1:0] psym_mem  [ac_pkg::NODES];
    logic [NW-1:0] suf_mem   [ac_pkg::NODES];
    logic [NW:0]   out_mem   [ac_pkg::NODES];
    logic [NW-1:0] q_mem     [ac_pkg::NODES];

    logic [NW-1:0] child_rd, trans_rd, par_rd, suf_rd, q_rd;
    logic [SW-1:0] psym_rd;
    logic [CW-1:0] term_rd;
    logic [NW:0]   out_rd;

    logic          child_we, trans_we, term_we, par_we, suf_we, out_we, q_we;
    logic [AW-1:0] child_waddr, child_raddr, trans_waddr, trans_raddr;
    logic [NW-1:0] child_wdata, trans_wdata;
    logic [NW-1:0] term_waddr, term_raddr, par_waddr, suf_waddr, out_waddr, out_raddr;
    logic [NW-1:0] q_waddr;
    logic [CW-1:0] term_wdata;
    logic [NW-1:0] suf_wdata, q_wdata;
    logic [NW:0]   out_wdata;

    // Control and working registers
    ac_pkg::t_state r_state, n_state;
    logic [AW-1:0]  r_clr, n_clr;
    logic [SW-1:0]  r_sym, n_sym;
    logic           r_last, n_last;
    logic [AW-1:0]  r_addr, n_addr;
    logic [NW-1:0]  r_ins_cur, n_ins_cur;
    logic [NW-1:0]  r_scan_cur, n_scan_cur;
    logic [ac_pkg::TOTAL_W-1:0] r_node_total, n_node_total;
    logic [NW-1:0]  r_node, n_node;
    logic           r_ovf, n_ovf;
    logic           r_zero, n_zero;
    logic [NW-1:0]  r_v, n_v;
    logic [NW-1:0]  r_s, n_s;
    logic [SW-1:0]  r_psym, n_psym;
    logic [AW-1:0]  r_vbase, n_vbase;
    logic [AW-1:0]  r_sbase, n_sbase;
    logic [SW-1:0]  r_col, n_col;
    logic           r_root, n_root;
    logic [NW-1:0]  r_head, n_head;
    logic [NW-1:0]  r_tail, n_tail;
    logic           r_ovalid, n_ovalid;
    logic [31:0]    r_odata, n_odata;

    logic           s_accept;
    logic [SW-1:0]  in_sym;
    logic           sym_ok;
    logic [NW-1:0]  row_val;

    assign o_s_axis_tready = (r_state == ac_pkg::S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign in_sym          = i_s_axis_tdata[SW-1:0];
    assign sym_ok          = (in_sym < SW'(ac_pkg::ALPHA));
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign row_val         = r_root ? '0 : trans_rd;

    // Memory write and read ports
    always_ff @(posedge i_clk) begin
        if (child_we) child_mem[child_waddr] <= child_wdata;
        child_rd <= child_mem[child_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (trans_we) trans_mem[trans_waddr] <= trans_wdata;
        trans_rd <= trans_mem[trans_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (term_we) term_mem[term_waddr] <= term_wdata;
        term_rd <= term_mem[term_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (par_we) begin
            par_mem[par_waddr]  <= r_ins_cur;
            psym_mem[par_waddr] <= r_sym;
        end
        par_rd  <= par_mem[q_rd];
        psym_rd <= psym_mem[q_rd];
    end

    always_ff @(posedge i_clk) begin
        if (suf_we) suf_mem[suf_waddr] <= suf_wdata;
        suf_rd <= suf_mem[par_rd];
    end

    always_ff @(posedge i_clk) begin
        if (out_we) out_mem[out_waddr] <= out_wdata;
        out_rd <= out_mem[out_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) q_mem[q_waddr] <= q_wdata;
        q_rd <= q_mem[r_head];
    end

    // Sequencer: next state, memory controls and result
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_sym        = r_sym;
        n_last       = r_last;
        n_addr       = r_addr;
        n_ins_cur    = r_ins_cur;
        n_scan_cur   = r_scan_cur;
        n_node_total = r_node_total;
        n_node       = r_node;
        n_ovf        = r_ovf;
        n_zero       = r_zero;
        n_v          = r_v;
        n_s          = r_s;
        n_psym       = r_psym;
        n_vbase      = r_vbase;
        n_sbase      = r_sbase;
        n_col        = r_col;
        n_root       = r_root;
        n_head       = r_head;
        n_tail       = r_tail;
        n_ovalid     = r_ovalid;
        n_odata      = r_odata;

        child_we    = 1'b0;
        child_waddr = r_addr;
        child_wdata = '0;
        child_raddr = ac_pkg::tbl_addr(r_ins_cur, in_sym);
        trans_we    = 1'b0;
        trans_waddr = r_vbase + AW'(r_col);
        trans_wdata = '0;
        trans_raddr = ac_pkg::tbl_addr(r_scan_cur, in_sym);
        term_we     = 1'b0;
        term_waddr  = r_node;
        term_wdata  = '0;
        term_raddr  = r_node;
        par_we      = 1'b0;
        par_waddr   = r_node_total[NW-1:0];
        suf_we      = 1'b0;
        suf_waddr   = r_v;
        suf_wdata   = r_s;
        out_we      = 1'b0;
        out_waddr   = r_v;
        out_wdata   = '0;
        out_raddr   = r_node;
        q_we        = 1'b0;
        q_waddr     = r_tail;
        q_wdata     = child_rd;

        // Release the output register once its transaction completes
        if (r_ovalid && i_m_axis_tready) n_ovalid = 1'b0;

        unique case (r_state)
            // Clear child and transition tables, counts and dictionary links
            ac_pkg::S_CLR: begin
                child_we    = 1'b1;
                child_waddr = r_clr;
                trans_we    = 1'b1;
                trans_waddr = r_clr;
                if (r_clr < AW'(ac_pkg::NODES)) begin
                    term_we    = 1'b1;
                    term_waddr = r_clr[NW-1:0];
                    out_we     = 1'b1;
                    out_waddr  = r_clr[NW-1:0];
                end
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(ac_pkg::TBL_DEPTH - 1)) n_state = ac_pkg::S_IDLE;
            end

            ac_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_sym  = in_sym;
                    n_last = i_s_axis_tlast;
                    n_ovf  = 1'b0;
                    n_zero = 1'b0;
                    n_addr = ac_pkg::tbl_addr(r_ins_cur, in_sym);
                    unique case (i_s_axis_tuser)
                        ac_pkg::ACT_INSERT: begin
                            if (sym_ok) begin
                                n_state = ac_pkg::S_INS_RD;
                            end else begin
                                n_node    = r_ins_cur;
                                n_ins_cur = i_s_axis_tlast ? '0 : r_ins_cur;
                                n_state   = ac_pkg::S_EMIT_RD;
                            end
                        end
                        ac_pkg::ACT_BUILD: begin
                            n_v     = '0;
                            n_s     = '0;
                            n_vbase = '0;
                            n_sbase = '0;
                            n_root  = 1'b1;
                            n_head  = '0;
                            n_tail  = '0;
                            n_state = ac_pkg::S_B_O;
                        end
                        ac_pkg::ACT_SCAN: begin
                            if (sym_ok) begin
                                n_state = ac_pkg::S_SCAN_RD;
                            end else begin
                                n_node     = '0;
                                n_scan_cur = '0;
                                n_state    = ac_pkg::S_EMIT_RD;
                            end
                        end
                        ac_pkg::ACT_NONE: begin
                            n_node  = '0;
                            n_zero  = 1'b1;
                            n_state = ac_pkg::S_EMIT_RD;
                        end
                        default: n_state = ac_pkg::S_IDLE;
                    endcase
                end
            end

            // Follow an existing child, or add a node if the trie has room
            ac_pkg::S_INS_RD: begin
                term_raddr = child_rd;
                n_state    = ac_pkg::S_EMIT_RD;
                if (child_rd != '0) begin
                    n_node    = child_rd;
                    n_ins_cur = r_last ? '0 : child_rd;
                    if (r_last) n_state = ac_pkg::S_INS_INC;
                end else if (r_node_total >= ac_pkg::TOTAL_W'(ac_pkg::NODES)) begin
                    n_ovf     = 1'b1;
                    n_node    = r_ins_cur;
                    n_ins_cur = r_last ? '0 : r_ins_cur;
                end else begin
                    child_we     = 1'b1;
                    child_wdata  = r_node_total[NW-1:0];
                    par_we       = 1'b1;
                    term_we      = 1'b1;
                    term_waddr   = r_node_total[NW-1:0];
                    term_wdata   = CW'(r_last);
                    n_node_total = r_node_total + 1'b1;
                    n_node       = r_node_total[NW-1:0];
                    n_ins_cur    = r_last ? '0 : r_node_total[NW-1:0];
                end
            end

            // Saturating pattern count
            ac_pkg::S_INS_INC: begin
                term_we    = 1'b1;
                term_wdata = (term_rd == ac_pkg::TERM_MAX) ? term_rd : term_rd + 1'b1;
                n_state    = ac_pkg::S_EMIT_RD;
            end

            ac_pkg::S_SCAN_RD: begin
                n_node     = trans_rd;
                n_scan_cur = r_last ? '0 : trans_rd;
                n_state    = ac_pkg::S_EMIT_RD;
            end

            // Take the next node off the breadth-first queue, or end the build when it is empty
            ac_pkg::S_B_POP: begin
                if (r_head == r_tail) begin
                    n_node  = '0;
                    n_zero  = 1'b1;
                    n_state = ac_pkg::S_EMIT_RD;
                end else begin
                    n_head  = r_head + 1'b1;
                    n_state = ac_pkg::S_B_V;
                end
            end

            ac_pkg::S_B_V: begin
                n_v     = q_rd;
                n_vbase = ac_pkg::tbl_addr(q_rd, '0);
                n_state = ac_pkg::S_B_P;
            end

            ac_pkg::S_B_P: begin
                n_psym = psym_rd;
                if (par_rd == '0) begin
                    n_s     = '0;
                    n_state = ac_pkg::S_B_S;
                end else begin
                    n_state = ac_pkg::S_B_SP;
                end
            end

            ac_pkg::S_B_SP: begin
                trans_raddr = ac_pkg::tbl_addr(suf_rd, r_psym);
                n_state     = ac_pkg::S_B_ST;
            end

            ac_pkg::S_B_ST: begin
                n_s     = trans_rd;
                n_state = ac_pkg::S_B_S;
            end

            // Store suffix link, fetch count and link of the suffix node
            ac_pkg::S_B_S: begin
                suf_we     = 1'b1;
                term_raddr = r_s;
                out_raddr  = r_s;
                n_sbase    = ac_pkg::tbl_addr(r_s, '0);
                n_state    = ac_pkg::S_B_O;
            end

            // Store dictionary link and open the row sweep
            ac_pkg::S_B_O: begin
                out_we      = 1'b1;
                out_wdata   = r_root ? '0 : ((term_rd != '0) ? {1'b1, r_s} : out_rd);
                child_raddr = r_vbase;
                trans_raddr = r_sbase;
                n_col       = '0;
                n_state     = ac_pkg::S_B_ROW;
            end

            // One transition entry per cycle; enqueue real children
            ac_pkg::S_B_ROW: begin
                trans_we    = 1'b1;
                trans_wdata = (child_rd != '0) ? child_rd : row_val;
                if (child_rd != '0) begin
                    q_we   = 1'b1;
                    n_tail = r_tail + 1'b1;
                end
                child_raddr = r_vbase + AW'(r_col) + AW'(1);
                trans_raddr = r_sbase + AW'(r_col) + AW'(1);
                if (r_col == SW'(ac_pkg::ALPHA - 1)) begin
                    n_root  = 1'b0;
                    n_state = ac_pkg::S_B_POP;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end

            ac_pkg::S_EMIT_RD: begin
                n_state = ac_pkg::S_EMIT;
            end

            // Load the result once the output register is free
            ac_pkg::S_EMIT: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {2'b00, r_ovf,
                                !r_zero && out_rd[NW],
                                (!r_zero && out_rd[NW]) ? out_rd[NW-1:0] : NW'(0),
                                r_zero ? CW'(0) : term_rd,
                                r_node};
                    n_state  = ac_pkg::S_IDLE;
                end
            end

            default: n_state = ac_pkg::S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ac_pkg::S_CLR;
            r_clr        <= '0;
            r_ins_cur    <= '0;
            r_scan_cur   <= '0;
            r_node_total <= ac_pkg::TOTAL_W'(1);
            r_ovalid     <= 1'b0;
            r_head       <= '0;
            r_tail       <= '0;
            r_root       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_ins_cur    <= n_ins_cur;
            r_scan_cur   <= n_scan_cur;
            r_node_total <= n_node_total;
            r_ovalid     <= n_ovalid;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_root       <= n_root;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_sym   <= n_sym;
        r_last  <= n_last;
        r_addr  <= n_addr;
        r_node  <= n_node;
        r_ovf   <= n_ovf;
        r_zero  <= n_zero;
        r_v     <= n_v;
        r_s     <= n_s;
        r_psym  <= n_psym;
        r_vbase <= n_vbase;
        r_sbase <= n_sbase;
        r_col   <= n_col;
        r_odata <= n_odata;
    end

`ifndef NO_ASSERTIONS
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_node_total != '0) && (r_node_total <= ac_pkg::TOTAL_W'(ac_pkg::NODES)))
        else $error("node total out of range");

    a_ovf_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ac_pkg::S_EMIT) && r_ovf |->
        (r_node_total == ac_pkg::TOTAL_W'(ac_pkg::NODES)))
        else $error("overflow reported with room left");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state != ac_pkg::S_IDLE))
        else $error("accepted transaction not processed");

    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ac_pkg::S_B_ROW) && (child_rd != '0) |->
        (r_tail != {NW{1'b1}}))
        else $error("queue tail wraps");
`endif

endmodule

/* bench/aho_corasick_matcher_tb.sv */
// Self-checking bench for the trie matcher: insert, link build and scan transactions.
`timescale 1ns / 1ps

module aho_corasick_matcher_tb;

    typedef struct {
        logic [1:0] action;
        logic [4:0] sym;
        logic       last;
        bit         hold;   // wait for all results before sending
    } t_req;

    typedef struct {
        logic [9:0] node;
        logic [7:0] count;
        logic [9:0] dlink;
        logic       has_dlink;
        logic       ovf;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = '0;   // [4:0] symbol, [7:5] zero
    logic [1:0]  i_s_axis_tuser = '0;   // [1:0] action
    logic        i_s_axis_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;        // [9:0] node, [17:10] count, [27:18] dict link,
                                        // [28] has dict link, [29] overflow

    aho_corasick_matcher i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Trie shadow: child entries hold node + 1, dictionary links hold node + 1
    int unsigned trie_child [ac_pkg::NODES*ac_pkg::ALPHA];
    int unsigned goto_next  [ac_pkg::NODES*ac_pkg::ALPHA];
    int unsigned pat_count  [ac_pkg::NODES];
    int unsigned up_node    [ac_pkg::NODES];
    int unsigned up_sym     [ac_pkg::NODES];
    int unsigned fail_link  [ac_pkg::NODES];
    int unsigned dict_plus1 [ac_pkg::NODES];
    int unsigned walk_order [ac_pkg::NODES];
    int unsigned trie_size = 1;
    int unsigned ins_at = 0;
    int unsigned scan_at = 0;

    t_req pending[$];
    t_res expected_results[$];
    int   errors = 0;

    function automatic t_res node_report(int unsigned n, bit ovf);
        t_res r;
        r.node      = n[9:0];
        r.count     = pat_count[n][7:0];
        r.has_dlink = dict_plus1[n] != 0;
        r.dlink     = r.has_dlink ? 10'(dict_plus1[n] - 1) : '0;
        r.ovf       = ovf;
        return r;
    endfunction

    // Breadth-first pass: suffix links, dictionary links, full goto table
    function automatic void build_automaton();
        int unsigned head, tail, v, p, s, c;
        head = 0;
        tail = 0;
        fail_link[0] = 0;
        dict_plus1[0] = 0;
        for (int i = 0; i < ac_pkg::ALPHA; i++) begin
            c = trie_child[i];
            if (c != 0 && tail < ac_pkg::NODES) begin
                goto_next[i] = c - 1;
                walk_order[tail] = c - 1;
                tail++;
            end else begin
                goto_next[i] = 0;
            end
        end
        while (head < tail) begin
            v = walk_order[head];
            head++;
            p = up_node[v];
            s = (p == 0) ? 0 : goto_next[fail_link[p]*ac_pkg::ALPHA + up_sym[v]];
            fail_link[v] = s;
            dict_plus1[v] = (pat_count[s] != 0) ? s + 1 : dict_plus1[s];
            for (int i = 0; i < ac_pkg::ALPHA; i++) begin
                c = trie_child[v*ac_pkg::ALPHA + i];
                if (c != 0 && tail < ac_pkg::NODES) begin
                    goto_next[v*ac_pkg::ALPHA + i] = c - 1;
                    walk_order[tail] = c - 1;
                    tail++;
                end else begin
                    goto_next[v*ac_pkg::ALPHA + i] = goto_next[s*ac_pkg::ALPHA + i];
                end
            end
        end
    endfunction

    function automatic t_res predict_match(t_req q);
        t_res r;
        int unsigned cur, c;
        bit ovf, ok;
        r = '{default: '0};
        case (q.action)
            ac_pkg::ACT_INSERT: begin
                cur = ins_at;
                ovf = 0;
                ok = 0;
                if (q.sym < ac_pkg::ALPHA) begin
                    c = trie_child[cur*ac_pkg::ALPHA + q.sym];
                    if (c != 0) begin
                        cur = c - 1;
                        ok = 1;
                    end else if (trie_size >= ac_pkg::NODES) begin
                        ovf = 1;
                    end else begin
                        trie_child[cur*ac_pkg::ALPHA + q.sym] = trie_size + 1;
                        up_node[trie_size] = cur;
                        up_sym[trie_size] = q.sym;
                        pat_count[trie_size] = 0;
                        cur = trie_size;
                        trie_size++;
                        ok = 1;
                    end
                end
                if (ok && q.last && pat_count[cur] < ac_pkg::TERM_MAX) pat_count[cur]++;
                r = node_report(cur, ovf);
                ins_at = q.last ? 0 : cur;
            end
            ac_pkg::ACT_BUILD: build_automaton();
            ac_pkg::ACT_SCAN: begin
                cur = (q.sym < ac_pkg::ALPHA) ? goto_next[scan_at*ac_pkg::ALPHA + q.sym] : 0;
                r = node_report(cur, 0);
                scan_at = q.last ? 0 : cur;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Driver: bursts of transactions separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        logic nxt_valid;
        t_req q;
        t_res pred;
        nxt_valid = i_s_axis_tvalid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                q.action = i_s_axis_tuser;
                q.sym = i_s_axis_tdata[4:0];
                q.last = i_s_axis_tlast;
                q.hold = 0;
                pred = predict_match(q);
                expected_results = {expected_results, pred};
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending.size() != 0 &&
                             !(pending[0].hold && expected_results.size() != 0)) begin
                    q = pending.pop_front();
                    i_s_axis_tuser <= q.action;
                    i_s_axis_tdata <= {3'b000, q.sym};
                    i_s_axis_tlast <= q.last;
                    nxt_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
        i_s_axis_tvalid <= nxt_valid;
    end

    // Monitor: stalls in phases of its own, compares every result transaction
    int stall_mode = 0;
    int mode_left = 0;
    always @(posedge i_clk) begin
        t_res e;
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction %h", o_m_axis_tdata);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_m_axis_tdata[9:0] !== e.node) begin
                    $error("node: expected %0d, got %0d", e.node, o_m_axis_tdata[9:0]);
                    errors++;
                end
                if (o_m_axis_tdata[17:10] !== e.count) begin
                    $error("match_count: expected %0d, got %0d", e.count,
                           o_m_axis_tdata[17:10]);
                    errors++;
                end
                if (o_m_axis_tdata[27:18] !== e.dlink) begin
                    $error("dict_link: expected %0d, got %0d", e.dlink,
                           o_m_axis_tdata[27:18]);
                    errors++;
                end
                if (o_m_axis_tdata[28] !== e.has_dlink) begin
                    $error("has_dict_link: expected %0b, got %0b", e.has_dlink,
                           o_m_axis_tdata[28]);
                    errors++;
                end
                if (o_m_axis_tdata[29] !== e.ovf) begin
                    $error("overflow: expected %0b, got %0b", e.ovf, o_m_axis_tdata[29]);
                    errors++;
                end
            end
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(10, 200);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: i_m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    function automatic void queue_item(logic [1:0] a, int s, bit l, bit h = 1'b0);
        t_req q;
        q.action = a;
        q.sym = 5'(s);
        q.last = l;
        q.hold = h;
        pending = {pending, q};
    endfunction

    // Short alphabet most of the time so that suffixes overlap
    function automatic int pick_sym();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
    endfunction

    initial begin
        int n, len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Scan before any build: every transition leads to the root
        queue_item(ac_pkg::ACT_SCAN, 0, 1'b0);
        queue_item(ac_pkg::ACT_SCAN, 25, 1'b1);
        // Patterns "ab", "b", "bab"; out-of-range and unused action mixed in
        queue_item(ac_pkg::ACT_INSERT, 0, 1'b0);
        queue_item(ac_pkg::ACT_INSERT, 1, 1'b1);
        queue_item(ac_pkg::ACT_INSERT, 1, 1'b1);
        queue_item(ac_pkg::ACT_INSERT, 1, 1'b0);
        queue_item(ac_pkg::ACT_INSERT, 31, 1'b0);
        queue_item(ac_pkg::ACT_INSERT, 0, 1'b0);
        queue_item(ac_pkg::ACT_INSERT, 1, 1'b1);
        queue_item(ac_pkg::ACT_INSERT, 26, 1'b1);
        queue_item(ac_pkg::ACT_NONE, 31, 1'b1);
        queue_item(ac_pkg::ACT_BUILD, 0, 1'b0, 1'b1);
        queue_item(ac_pkg::ACT_SCAN, 1, 1'b0, 1'b1);
        queue_item(ac_pkg::ACT_SCAN, 0, 1'b0);
        queue_item(ac_pkg::ACT_SCAN, 1, 1'b0);
        queue_item(ac_pkg::ACT_SCAN, 27, 1'b0);
        queue_item(ac_pkg::ACT_SCAN, 0, 1'b0);
        queue_item(ac_pkg::ACT_SCAN, 1, 1'b1);
        queue_item(ac_pkg::ACT_BUILD, 30, 1'b1);

        // Count saturation on the single-letter pattern "z"
        for (int i = 0; i < 260; i++) queue_item(ac_pkg::ACT_INSERT, 25, 1'b1);
        queue_item(ac_pkg::ACT_BUILD, 0, 1'b0);
        queue_item(ac_pkg::ACT_SCAN, 25, 1'b1);

        // Random mix: mostly well-formed patterns and texts, some noise
        n = 0;
        while (n < 320) begin
            case ($urandom_range(0, 19))
                0: begin
                    queue_item(ac_pkg::ACT_BUILD, $urandom_range(0, 31),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    n++;
                end
                1, 2, 3, 4, 5, 6, 7: begin
                    len = $urandom_range(1, 5);
                    for (int i = 0; i < len; i++)
                        queue_item(ac_pkg::ACT_INSERT, pick_sym(), i == len-1);
                    n += len;
                end
                8: begin
                    queue_item(2'($urandom_range(0, 3)), $urandom_range(0, 31),
                               1'($urandom_range(0, 1)));
                    n++;
                end
                default: begin
                    len = $urandom_range(1, 12);
                    for (int i = 0; i < len; i++)
                        queue_item(ac_pkg::ACT_SCAN, pick_sym(), i == len-1);
                    n += len;
                end
            endcase
        end

        // Final build after a full drain, then a long text
        queue_item(ac_pkg::ACT_BUILD, 0, 1'b0, 1'b1);
        for (int i = 0; i < 200; i++)
            queue_item(ac_pkg::ACT_SCAN, (i < 150) ? $urandom_range(0, 25) : pick_sym(),
                       $urandom_range(0, 15) == 0);

        wait (pending.size() == 0 && !i_s_axis_tvalid && expected_results.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
